// ===== hw/rtl/hat_pkg.sv =====
// hat_pkg: sizes, entry record, compare result and sequencer states
// for the heartbeat aging table. No dependencies.
package hat_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int EXP_W = 16;
  localparam int OCNT_W = 5;
  localparam logic [EXP_W-1:0] EXPIRY_RESET = 16'd60;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

  typedef struct packed {
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] last_seen;
  } entry_t;

  typedef struct packed {
    logic match;
    logic expired;
  } cmp_result_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_TAIL = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
    if (32'(v) > 32'd31) begin
      return 5'd31;
    end
    return OCNT_W'(v);
  endfunction

endpackage

// ===== hw/rtl/hat_store.sv =====
// hat_store: entry memory (ip, port, last seen), one write port and one
// registered read port. Depends on hat_pkg.
module hat_store
  import hat_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  entry_t           wr_data,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/hat_cmp.sv =====
// hat_cmp: shared key compare and age check applied to one entry per cycle.
// Depends on hat_pkg.
module hat_cmp
  import hat_pkg::*;
(
  input  entry_t             ent,
  input  logic               ent_valid,
  input  logic [31:0]        key_ip,
  input  logic [15:0]        key_port,
  input  logic [31:0]        now,
  input  logic [EXP_W-1:0]   expiry,
  output cmp_result_t        res
);

  logic [31:0] age;

  assign age = now - ent.last_seen;
  assign res.match = ent_valid && (ent.ip == key_ip) && (ent.port == key_port);
  assign res.expired = ent_valid && (age > {{(32-EXP_W){1'b0}}, expiry});

endmodule

// ===== hw/rtl/heartbeat_aging_table.sv =====
// heartbeat_aging_table: live server table with heartbeat refresh and expiry sweep.
// Every request walks all TABLE_ENTRIES entries through one compare unit, one per cycle.
// After start is taken the sequencer steps through ST_SCAN, ST_TAIL and ST_FIN;
// out_valid is registered as ST_FIN ends. busy is high in all of those states, so a new
// request is taken only once the previous one is done and the sequencer is in ST_IDLE.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset (rst_n low, synchronous): table empty, count zero, expiry 60. Uses hat_pkg.
module heartbeat_aging_table
  import hat_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_req_type,
  input  logic [31:0]       in_ip_addr,
  input  logic [15:0]       in_port_number,
  input  logic [31:0]       in_now_seconds,
  input  logic              cfg_we,
  input  logic [EXP_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic              out_refreshed,
  output logic              out_added,
  output logic              out_dropped_full,
  output logic [OCNT_W-1:0] out_removed_count,
  output logic              out_list_changed,
  output logic [OCNT_W-1:0] out_entry_count
);

  state_t state_r, state_nxt;
  logic [EXP_W-1:0] expiry_r;

  logic req_type_r, req_type_nxt;
  logic [31:0] req_ip_r, req_ip_nxt;
  logic [15:0] req_port_r, req_port_nxt;
  logic [31:0] req_now_r, req_now_nxt;

  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic eval_vld_r, eval_vld_nxt;
  logic [IDX_W-1:0] eval_idx_r, eval_idx_nxt;
  logic hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic free_r, free_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0] rm_cnt_r, rm_cnt_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] valid_cnt_r, valid_cnt_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_refreshed_r, out_refreshed_nxt;
  logic out_added_r, out_added_nxt;
  logic out_dropped_r, out_dropped_nxt;
  logic [OCNT_W-1:0] out_removed_r, out_removed_nxt;
  logic out_changed_r, out_changed_nxt;
  logic [OCNT_W-1:0] out_count_r, out_count_nxt;

  logic wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t wr_data;
  entry_t rd_data;
  cmp_result_t cmp_res;

  hat_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_idx  (rd_idx_r),
    .rd_data (rd_data)
  );

  hat_cmp u_cmp (
    .ent       (rd_data),
    .ent_valid (valid_r[eval_idx_r]),
    .key_ip    (req_ip_r),
    .key_port  (req_port_r),
    .now       (req_now_r),
    .expiry    (expiry_r),
    .res       (cmp_res)
  );

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    req_type_nxt = req_type_r;
    req_ip_nxt = req_ip_r;
    req_port_nxt = req_port_r;
    req_now_nxt = req_now_r;
    rd_idx_nxt = rd_idx_r;
    eval_vld_nxt = 1'b0;
    eval_idx_nxt = rd_idx_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    free_nxt = free_r;
    free_idx_nxt = free_idx_r;
    rm_cnt_nxt = rm_cnt_r;
    valid_nxt = valid_r;
    valid_cnt_nxt = valid_cnt_r;
    out_valid_nxt = 1'b0;
    out_refreshed_nxt = out_refreshed_r;
    out_added_nxt = out_added_r;
    out_dropped_nxt = out_dropped_r;
    out_removed_nxt = out_removed_r;
    out_changed_nxt = out_changed_r;
    out_count_nxt = out_count_r;
    wr_en = 1'b0;
    wr_idx = hit_r ? hit_idx_r : free_idx_r;
    wr_data.ip = req_ip_r;
    wr_data.port = req_port_r;
    wr_data.last_seen = req_now_r;

    // per-entry evaluation, in the cycle after the read
    if (eval_vld_r) begin
      if (req_type_r == REQ_SWEEP) begin
        if (cmp_res.expired) begin
          valid_nxt[eval_idx_r] = 1'b0;
          rm_cnt_nxt = rm_cnt_r + 1'b1;
        end
      end else begin
        if (cmp_res.match && !hit_r) begin
          hit_nxt = 1'b1;
          hit_idx_nxt = eval_idx_r;
        end
        if (!valid_r[eval_idx_r] && !free_r) begin
          free_nxt = 1'b1;
          free_idx_nxt = eval_idx_r;
        end
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_type_nxt = in_req_type;
          req_ip_nxt = in_ip_addr;
          req_port_nxt = in_port_number;
          req_now_nxt = in_now_seconds;
          rd_idx_nxt = '0;
          hit_nxt = 1'b0;
          free_nxt = 1'b0;
          rm_cnt_nxt = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        eval_vld_nxt = 1'b1;
        eval_idx_nxt = rd_idx_r;
        if (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_nxt = ST_TAIL;
        end else begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end
      end
      ST_TAIL: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        out_refreshed_nxt = 1'b0;
        out_added_nxt = 1'b0;
        out_dropped_nxt = 1'b0;
        out_removed_nxt = '0;
        out_changed_nxt = 1'b0;
        if (req_type_r == REQ_SWEEP) begin
          valid_cnt_nxt = valid_cnt_r - rm_cnt_r;
          out_removed_nxt = sat_cnt(rm_cnt_r);
          out_changed_nxt = (rm_cnt_r != '0);
        end else if (hit_r) begin
          wr_en = 1'b1;
          out_refreshed_nxt = 1'b1;
        end else if (free_r) begin
          wr_en = 1'b1;
          valid_nxt[free_idx_r] = 1'b1;
          valid_cnt_nxt = valid_cnt_r + 1'b1;
          out_added_nxt = 1'b1;
        end else begin
          out_dropped_nxt = 1'b1;
        end
        out_count_nxt = sat_cnt(valid_cnt_nxt);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      expiry_r <= EXPIRY_RESET;
      valid_r <= '0;
      valid_cnt_r <= '0;
      eval_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        expiry_r <= cfg_wdata;
      end
      valid_r <= valid_nxt;
      valid_cnt_r <= valid_cnt_nxt;
      eval_vld_r <= eval_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r <= req_type_nxt;
    req_ip_r <= req_ip_nxt;
    req_port_r <= req_port_nxt;
    req_now_r <= req_now_nxt;
    rd_idx_r <= rd_idx_nxt;
    eval_idx_r <= eval_idx_nxt;
    hit_r <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    free_r <= free_nxt;
    free_idx_r <= free_idx_nxt;
    rm_cnt_r <= rm_cnt_nxt;
    out_refreshed_r <= out_refreshed_nxt;
    out_added_r <= out_added_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_removed_r <= out_removed_nxt;
    out_changed_r <= out_changed_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_refreshed = out_refreshed_r;
  assign out_added = out_added_r;
  assign out_dropped_full = out_dropped_r;
  assign out_removed_count = out_removed_r;
  assign out_list_changed = out_changed_r;
  assign out_entry_count = out_count_r;

  a_fin_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> out_valid_r)
    else $error("result strobe missing after finish");

  a_reg_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (req_type_r == REQ_REGISTER)) |->
      $onehot({out_refreshed_r, out_added_r, out_dropped_r}))
    else $error("register request must have exactly one outcome");

  a_count_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (valid_cnt_r == CNT_W'($countones(valid_r))))
    else $error("entry count out of step with valid bits");

  a_sweep_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (req_type_r == REQ_SWEEP)) |->
      (!out_refreshed_r && !out_added_r && !out_dropped_r &&
       (out_changed_r == (out_removed_r != '0))))
    else $error("sweep result flags inconsistent");

endmodule

// ===== tb/sv/heartbeat_aging_table_test.sv =====
// heartbeat_aging_table_test: self-checking testbench for heartbeat_aging_table.
// Directed table then randomized register/sweep requests over several expiry settings,
// checked against an in-bench table predictor. Depends on hat_pkg and the RTL only.
module heartbeat_aging_table_test;
  import hat_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int KEY_POOL = 24;
  localparam int DIR_ROWS = 25;

  typedef struct packed {
    logic              refreshed;
    logic              added;
    logic              dropped_full;
    logic [OCNT_W-1:0] removed_count;
    logic              list_changed;
    logic [OCNT_W-1:0] entry_count;
  } outcome_t;

  typedef struct packed {
    logic        req_type;
    logic [31:0] ip;
    logic [15:0] port;
    logic [31:0] now;
    logic        typed;
    outcome_t    res;
  } dir_row_t;

  // typed rows carry the outcome; the rest are predicted
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{REQ_SWEEP,    32'hffff_ffff, 16'hffff, 32'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 5'd0,  1'b0, 5'd0}},
    '{REQ_REGISTER, 32'h0000_0000, 16'h0000, 32'd100, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd0,  1'b0, 5'd1}},
    '{REQ_REGISTER, 32'hffff_ffff, 16'hffff, 32'd100, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd0,  1'b0, 5'd2}},
    '{REQ_REGISTER, 32'h0000_0000, 16'hffff, 32'd100, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd0,  1'b0, 5'd3}},
    '{REQ_REGISTER, 32'hffff_ffff, 16'h0000, 32'd130, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd0,  1'b0, 5'd4}},
    '{REQ_REGISTER, 32'h0000_0000, 16'h0000, 32'd130, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0,  1'b0, 5'd4}},
    // age equal to expiry stays, one past it goes
    '{REQ_SWEEP,    32'h0000_0000, 16'h0000, 32'd160, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0,  1'b0, 5'd4}},
    '{REQ_SWEEP,    32'h5555_aaaa, 16'h5a5a, 32'd161, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd2,  1'b1, 5'd2}},
    '{REQ_REGISTER, 32'h0a00_0001, 16'd1001, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0002, 16'd1002, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0003, 16'd1003, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0004, 16'd1004, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0005, 16'd1005, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0006, 16'd1006, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0007, 16'd1007, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0008, 16'd1008, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_0009, 16'd1009, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_000a, 16'd1010, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_000b, 16'd1011, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_000c, 16'd1012, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_000d, 16'd1013, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'h0a00_000e, 16'd1014, 32'd200, 1'b0, '0},
    '{REQ_REGISTER, 32'hc0a8_0001, 16'd8080, 32'd200, 1'b1, '{1'b0, 1'b0, 1'b1, 5'd0,  1'b0, 5'd16}},
    '{REQ_REGISTER, 32'h0a00_0007, 16'd1007, 32'd200, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd0,  1'b0, 5'd16}},
    // last_seen ahead of now: wrapped age expires everything
    '{REQ_SWEEP,    32'h0000_0000, 16'h0000, 32'd50,  1'b1, '{1'b0, 1'b0, 1'b0, 5'd16, 1'b1, 5'd0}}
  };

  logic              clk;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_req_type = 1'b0;
  logic [31:0]       in_ip_addr = '0;
  logic [15:0]       in_port_number = '0;
  logic [31:0]       in_now_seconds = '0;
  logic              cfg_we = 1'b0;
  logic [EXP_W-1:0]  cfg_wdata = '0;
  logic              out_valid;
  logic              out_refreshed;
  logic              out_added;
  logic              out_dropped_full;
  logic [OCNT_W-1:0] out_removed_count;
  logic              out_list_changed;
  logic [OCNT_W-1:0] out_entry_count;

  heartbeat_aging_table u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_ip_addr        (in_ip_addr),
    .in_port_number    (in_port_number),
    .in_now_seconds    (in_now_seconds),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_refreshed     (out_refreshed),
    .out_added         (out_added),
    .out_dropped_full  (out_dropped_full),
    .out_removed_count (out_removed_count),
    .out_list_changed  (out_list_changed),
    .out_entry_count   (out_entry_count)
  );

  // predicted table contents
  logic             tbl_valid [TABLE_ENTRIES] = '{default: 1'b0};
  logic [31:0]      tbl_ip [TABLE_ENTRIES];
  logic [15:0]      tbl_port [TABLE_ENTRIES];
  logic [31:0]      tbl_seen [TABLE_ENTRIES];
  int unsigned      live_count = 0;
  logic [EXP_W-1:0] model_expiry = EXPIRY_RESET;

  outcome_t    expected_outcomes [$];
  int          errors = 0;
  int          idle_cycles = 0;
  logic [31:0] sim_now;
  logic [31:0] pool_ip [KEY_POOL];
  logic [15:0] pool_port [KEY_POOL];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic outcome_t table_outcome(input logic req, input logic [31:0] ip,
                                             input logic [15:0] port, input logic [31:0] now);
    outcome_t    o;
    int          free_slot;
    bit          hit;
    int unsigned removed;
    logic [31:0] age;
    o = '0;
    free_slot = -1;
    hit = 1'b0;
    removed = 0;
    if (req == REQ_REGISTER) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          if (!hit && tbl_ip[i] == ip && tbl_port[i] == port) begin
            tbl_seen[i] = now;
            hit = 1'b1;
          end
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit) begin
        o.refreshed = 1'b1;
      end else if (free_slot >= 0) begin
        tbl_valid[free_slot] = 1'b1;
        tbl_ip[free_slot] = ip;
        tbl_port[free_slot] = port;
        tbl_seen[free_slot] = now;
        live_count++;
        o.added = 1'b1;
      end else begin
        o.dropped_full = 1'b1;
      end
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_valid[i]) begin
          age = now - tbl_seen[i];
          if (age > 32'(model_expiry)) begin
            tbl_valid[i] = 1'b0;
            removed++;
          end
        end
      end
      live_count -= removed;
    end
    o.removed_count = (removed > 31) ? 5'd31 : OCNT_W'(removed);
    o.list_changed = (removed != 0);
    o.entry_count = (live_count > 31) ? 5'd31 : OCNT_W'(live_count);
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid) begin
      if (expected_outcomes.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("refreshed", 32'(want.refreshed), 32'(out_refreshed));
        check_field("added", 32'(want.added), 32'(out_added));
        check_field("dropped_full", 32'(want.dropped_full), 32'(out_dropped_full));
        check_field("removed_count", 32'(want.removed_count), 32'(out_removed_count));
        check_field("list_changed", 32'(want.list_changed), 32'(out_list_changed));
        check_field("entry_count", 32'(want.entry_count), 32'(out_entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(input logic req, input logic [31:0] ip, input logic [15:0] port,
                              input logic [31:0] now, input logic typed,
                              input outcome_t typed_res);
    outcome_t predicted;
    start <= 1'b1;
    in_req_type <= req;
    in_ip_addr <= ip;
    in_port_number <= port;
    in_now_seconds <= now;
    do @(posedge clk); while (busy);
    predicted = table_outcome(req, ip, port, now);
    if (typed) begin
      predicted = typed_res;
    end
    expected_outcomes = {expected_outcomes, predicted};
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_outcomes.size() != 0 || busy);
  endtask

  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_expiry(input logic [EXP_W-1:0] value);
    wait_all_results();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    model_expiry = value;
    cfg_we <= 1'b0;
    cfg_wdata <= EXP_W'($urandom());
  endtask

  task automatic run_phase(input logic [EXP_W-1:0] expiry_value, input logic [31:0] start_time,
                           input int items);
    int          sent;
    int          burst;
    int          pick;
    int          k;
    int          step_max;
    logic        req;
    logic [31:0] ip;
    logic [15:0] port;
    write_expiry(expiry_value);
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_ip[i] = $urandom();
      pool_port[i] = 16'($urandom_range(0, 65535));
    end
    sim_now = start_time;
    step_max = int'(expiry_value) / 8 + 2;
    sent = 0;
    while (sent < items) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < items; b++) begin
        if ($urandom_range(0, 19) == 0) begin
          sim_now = $urandom();
        end else begin
          sim_now = sim_now + 32'($urandom_range(0, step_max));
        end
        req = ($urandom_range(0, 4) == 0) ? REQ_SWEEP : REQ_REGISTER;
        if ($urandom_range(0, 7) == 0) begin
          ip = $urandom();
          port = 16'($urandom_range(0, 65535));
        end else begin
          k = $urandom_range(0, KEY_POOL - 1);
          ip = pool_ip[k];
          port = pool_port[k];
        end
        send_request(req, ip, port, sim_now, 1'b0, '0);
        sent++;
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        wait_all_results();
      end else if (pick < 10) begin
        idle_gap($urandom_range(1, 30));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(DIRECTED_ROWS[r].req_type, DIRECTED_ROWS[r].ip, DIRECTED_ROWS[r].port,
                   DIRECTED_ROWS[r].now, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
      if ($urandom_range(0, 2) == 0) begin
        idle_gap($urandom_range(1, 20));
      end
    end

    run_phase(16'd0, $urandom(), ITEMS_PER_PHASE);
    run_phase(16'hffff, 32'hffff_0000, ITEMS_PER_PHASE);
    run_phase(16'd1, 32'hffff_ffc0, ITEMS_PER_PHASE);
    run_phase(16'd60, $urandom(), ITEMS_PER_PHASE);
    run_phase(16'($urandom_range(0, 65535)), $urandom(), ITEMS_PER_PHASE);
    run_phase(16'($urandom_range(2, 300)), $urandom(), ITEMS_PER_PHASE);

    wait_all_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
